[rtl/ltc_pkg.sv]
package ltc_pkg;

  localparam int unsigned RID_W  = 16;
  localparam int unsigned FONT_W = 16;
  localparam int unsigned COL_W  = 32;
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W = 8;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_FILL   = 2'd1,
    STAT_BYPASS = 2'd2,
    STAT_NONE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

endpackage

[rtl/ltc_ram.sv]
module ltc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lru_text_cache_lookup.sv]
// Fully associative text cache with timestamp LRU. One request word in, one
// result word out. For a cached lookup the entry memories are read one
// entry per cycle in a single scan that finds the match, the lowest free
// slot and the oldest stamp, followed by a write-back state. Empty text
// and bypass lengths go from the check straight to the result. Reset and
// a renderer change mark every entry invalid at once; the valid memory
// itself is cleared during the next scan. Only one request is in flight at
// a time; a new word is taken once the previous result has been taken.
module lru_text_cache_lookup
  import ltc_pkg::*;
#(
  parameter int unsigned ENTRIES        = 256,
  parameter int unsigned MAX_KEY_LENGTH = 192,
  parameter int unsigned TAG_BITS       = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RID_W-1:0]   renderer_id,
  input  logic [FONT_W-1:0]  font_id,
  input  logic [COL_W-1:0]   color_rgba,
  input  logic [KEY_W-1:0]   key_tag,
  input  logic [LEN_W-1:0]   text_length,
  input  logic               build_ok,
  input  logic [DIM_W-1:0]   built_width,
  input  logic [DIM_W-1:0]   built_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [DIM_W-1:0]   out_width,
  output logic [DIM_W-1:0]   out_height,
  output logic               evicted,
  output logic               cleared
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned TW    = (TAG_BITS < KEY_W) ? TAG_BITS : KEY_W;
  localparam int unsigned DW    = FONT_W + COL_W + TW + 2 * DIM_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [LEN_W:0]   BYPASS_LEN = (LEN_W + 1)'(MAX_KEY_LENGTH - 1);

  state_t state, state_next;

  logic [RID_W-1:0]   req_rid;
  logic [FONT_W-1:0]  req_font;
  logic [COL_W-1:0]   req_col;
  logic [TW-1:0]      req_tag;
  logic [LEN_W-1:0]   req_len;
  logic               req_ok;
  logic [DIM_W-1:0]   req_w;
  logic [DIM_W-1:0]   req_h;

  logic [RID_W-1:0]   cur_rid;
  logic [STAMP_W-1:0] use_counter;
  logic               flush;

  logic [IDX_W-1:0]   rd_addr;
  logic               rd_issue;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;

  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [DIM_W-1:0]   hit_w;
  logic [DIM_W-1:0]   hit_h;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               old_found;
  logic [IDX_W-1:0]   old_idx;
  logic [STAMP_W-1:0] old_stamp;

  logic [DW-1:0]      data_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               vld_q;
  logic               data_we;
  logic               stamp_we;
  logic               vld_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [DW-1:0]      wr_data;
  logic [IDX_W-1:0]   vld_waddr;
  logic               vld_wdata;

  logic [FONT_W-1:0]  q_font;
  logic [COL_W-1:0]   q_col;
  logic [TW-1:0]      q_tag;
  logic [DIM_W-1:0]   q_w;
  logic [DIM_W-1:0]   q_h;
  logic               q_valid;
  logic               q_match;

  logic               is_empty;
  logic               is_bypass;
  logic               rid_change;
  logic [IDX_W-1:0]   fill_idx;

  ltc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_idx),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (data_q)
  );

  ltc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (use_counter),
    .raddr (rd_addr),
    .rdata (stamp_q)
  );

  ltc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (rd_addr),
    .rdata (vld_q)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_RESP);

  assign is_empty   = (req_len == '0);
  assign is_bypass  = ({1'b0, req_len} >= BYPASS_LEN);
  assign rid_change = (req_rid != cur_rid);

  assign {q_font, q_col, q_tag, q_w, q_h} = data_q;
  assign q_valid = vld_q && !flush;
  assign q_match = (q_font == req_font) && (q_col == req_col) && (q_tag == req_tag);

  assign fill_idx = free_found ? free_idx : old_idx;
  assign wr_idx   = hit_found ? hit_idx : fill_idx;
  assign wr_data  = {req_font, req_col, req_tag, req_w, req_h};
  assign data_we  = (state == ST_UPDATE) && !hit_found && req_ok;
  assign stamp_we = (state == ST_UPDATE) && (hit_found || req_ok);

  // pending clear is written back entry by entry as the scan passes
  assign vld_we    = ((state == ST_SCAN) && rd_vld && flush) ||
                     ((state == ST_UPDATE) && !hit_found);
  assign vld_waddr = (state == ST_UPDATE) ? fill_idx : rd_idx;
  assign vld_wdata = (state == ST_UPDATE) && req_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = (is_empty || is_bypass) ? ST_RESP : ST_SCAN;
      ST_SCAN:   if (rd_vld && rd_idx == LAST_IDX) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_RESP:   if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_rid  <= renderer_id;
      req_font <= font_id;
      req_col  <= color_rgba;
      req_tag  <= TW'(key_tag);
      req_len  <= text_length;
      req_ok   <= build_ok;
      req_w    <= built_width;
      req_h    <= built_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_rid     <= '0;
      use_counter <= STAMP_W'(1);
      flush       <= 1'b1;
    end else begin
      if (state == ST_CHECK && !is_empty && rid_change) begin
        cur_rid <= req_rid;
        flush   <= 1'b1;
      end
      if (state == ST_UPDATE) begin
        flush <= 1'b0;
      end
      if (stamp_we) begin
        use_counter <= use_counter + STAMP_W'(1);
      end
    end
  end

  // scan: issue one read per cycle, compare the read data in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_issue <= 1'b0;
      rd_vld   <= 1'b0;
    end else if (state == ST_CHECK) begin
      rd_issue <= 1'b1;
      rd_vld   <= 1'b0;
    end else if (state == ST_SCAN) begin
      rd_vld <= rd_issue;
      if (rd_issue && rd_addr == LAST_IDX) rd_issue <= 1'b0;
    end else begin
      rd_issue <= 1'b0;
      rd_vld   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      rd_addr    <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (rd_issue && rd_addr != LAST_IDX) rd_addr <= rd_addr + IDX_W'(1);
      rd_idx <= rd_addr;
      if (rd_vld) begin
        if (q_valid) begin
          if (!hit_found && q_match) begin
            hit_found <= 1'b1;
            hit_idx   <= rd_idx;
            hit_w     <= q_w;
            hit_h     <= q_h;
          end
          if (!old_found || stamp_q < old_stamp) begin
            old_found <= 1'b1;
            old_idx   <= rd_idx;
            old_stamp <= stamp_q;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      cleared    <= !is_empty && rid_change;
      evicted    <= 1'b0;
      slot_index <= '0;
      if (!is_empty && is_bypass && req_ok) begin
        status     <= STAT_BYPASS;
        out_width  <= req_w;
        out_height <= req_h;
      end else begin
        status     <= STAT_NONE;
        out_width  <= '0;
        out_height <= '0;
      end
    end else if (state == ST_UPDATE) begin
      if (hit_found) begin
        status     <= STAT_HIT;
        slot_index <= SLOT_W'(hit_idx);
        out_width  <= hit_w;
        out_height <= hit_h;
      end else begin
        evicted <= !free_found;
        if (req_ok) begin
          status     <= STAT_FILL;
          slot_index <= SLOT_W'(fill_idx);
          out_width  <= req_w;
          out_height <= req_h;
        end else begin
          status     <= STAT_NONE;
          slot_index <= '0;
          out_width  <= '0;
          out_height <= '0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_counter_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPDATE) |=> $stable(use_counter))
    else $error("use counter moved outside write-back");

  a_compare_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN))
    else $error("read data compared outside scan");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && hit_found) |-> !flush)
    else $error("hit on invalid entry");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHECK))
    else $error("accepted word not checked");

  a_evict_no_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !hit_found && !free_found) |-> old_found)
    else $error("eviction without victim");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ltc_pkg::*;

  localparam int NSLOT = 256;
  localparam int BYPASS_LEN = 191;
  localparam int N_RAND = 830;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [RID_W-1:0] renderer_id = '0;
  logic [FONT_W-1:0] font_id = '0;
  logic [COL_W-1:0] color_rgba = '0;
  logic [KEY_W-1:0] key_tag = '0;
  logic [LEN_W-1:0] text_length = '0;
  logic build_ok = 1'b0;
  logic [DIM_W-1:0] built_width = '0;
  logic [DIM_W-1:0] built_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [DIM_W-1:0] out_width;
  logic [DIM_W-1:0] out_height;
  logic evicted;
  logic cleared;

  lru_text_cache_lookup u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .renderer_id(renderer_id), .font_id(font_id), .color_rgba(color_rgba),
    .key_tag(key_tag), .text_length(text_length), .build_ok(build_ok),
    .built_width(built_width), .built_height(built_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_index(slot_index), .out_width(out_width),
    .out_height(out_height), .evicted(evicted), .cleared(cleared)
  );

  typedef struct packed {
    logic [RID_W-1:0] rid;
    logic [FONT_W-1:0] font;
    logic [COL_W-1:0] col;
    logic [KEY_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic ok;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } request_t;

  typedef struct packed {
    status_t st;
    logic [SLOT_W-1:0] slot;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic ev;
    logic cl;
  } lookup_t;

  // cache shadow
  logic c_valid [NSLOT];
  logic [FONT_W-1:0] c_font [NSLOT];
  logic [COL_W-1:0] c_col [NSLOT];
  logic [KEY_W-1:0] c_tag [NSLOT];
  logic [DIM_W-1:0] c_w [NSLOT];
  logic [DIM_W-1:0] c_h [NSLOT];
  logic [STAMP_W-1:0] c_stamp [NSLOT];
  logic [STAMP_W-1:0] use_cnt;
  logic [RID_W-1:0] cur_rid;

  lookup_t pending_lookups [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;

  // recent keys for reuse
  request_t recent [$];

  function automatic lookup_t predict_lookup(request_t r);
    lookup_t o;
    int hit, fr, old;
    hit = -1; fr = -1; old = 0;
    o = '{STAT_NONE, '0, '0, '0, 1'b0, 1'b0};
    if (r.len == 0) return o;
    if (r.rid != cur_rid) begin
      foreach (c_valid[i]) c_valid[i] = 1'b0;
      cur_rid = r.rid;
      o.cl = 1'b1;
    end
    if (r.len >= BYPASS_LEN) begin
      if (r.ok) begin
        o.st = STAT_BYPASS; o.w = r.w; o.h = r.h;
      end
      return o;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (c_valid[i]) begin
        if (hit < 0 && c_font[i] == r.font && c_col[i] == r.col && c_tag[i] == r.tag)
          hit = i;
        if (c_stamp[i] < c_stamp[old]) old = i;
      end else if (fr < 0) begin
        fr = i;
      end
    end
    if (hit >= 0) begin
      c_stamp[hit] = use_cnt;
      use_cnt++;
      o.st = STAT_HIT; o.slot = SLOT_W'(hit); o.w = c_w[hit]; o.h = c_h[hit];
      return o;
    end
    if (fr < 0) begin
      fr = old; c_valid[old] = 1'b0; o.ev = 1'b1;
    end
    if (!r.ok) return o;
    c_valid[fr] = 1'b1; c_font[fr] = r.font; c_col[fr] = r.col; c_tag[fr] = r.tag;
    c_w[fr] = r.w; c_h[fr] = r.h; c_stamp[fr] = use_cnt;
    use_cnt++;
    o.st = STAT_FILL; o.slot = SLOT_W'(fr); o.w = r.w; o.h = r.h;
    return o;
  endfunction

  // returns at the accepting edge; valid stays high until the next falling edge
  task automatic send_word(request_t r);
    @(negedge clk);
    while ($urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    renderer_id <= r.rid; font_id <= r.font; color_rgba <= r.col; key_tag <= r.tag;
    text_length <= r.len; build_ok <= r.ok; built_width <= r.w; built_height <= r.h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lookups.push_back(predict_lookup(r));
    recent.push_back(r);
    if (recent.size() > 40) void'(recent.pop_front());
  endtask

  function automatic request_t rand_word(logic [RID_W-1:0] rid);
    request_t r;
    int k;
    r.rid = rid;
    k = $urandom_range(99);
    if (k < 45 && recent.size() > 0) begin
      r = recent[$urandom_range(recent.size() - 1)];
      r.rid = rid;
    end else begin
      r.font = $urandom_range(7) == 0 ? FONT_W'($urandom()) : FONT_W'($urandom_range(3));
      r.col = $urandom_range(7) == 0 ? COL_W'($urandom()) : COL_W'($urandom_range(3));
      r.tag = KEY_W'({$urandom(), $urandom()});
      if ($urandom_range(3) == 0) r.tag = KEY_W'($urandom_range(15));
    end
    k = $urandom_range(99);
    r.len = k < 5 ? LEN_W'(0) :
            k < 15 ? LEN_W'($urandom_range(255, BYPASS_LEN - 1)) :
            LEN_W'($urandom_range(189, 1));
    r.ok = $urandom_range(9) != 0;
    r.w = DIM_W'($urandom()); r.h = DIM_W'($urandom());
    return r;
  endfunction

  // directed rows; known result typed where obvious, else predictor only
  typedef struct packed {
    request_t r;
    bit known;
    lookup_t exp;
  } row_t;

  row_t rows [$];

  initial begin
    request_t r;
    logic [RID_W-1:0] rid;
    int burst;
    foreach (c_valid[i]) c_valid[i] = 1'b0;
    use_cnt = STAMP_W'(1); cur_rid = '0;
    rows = '{
      '{'{16'h0, 16'h0, 32'h0, 48'h0, 8'd0, 1'b1, 12'hFFF, 12'hFFF}, 1'b1,
        '{STAT_NONE, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0}},
      '{'{16'h0, 16'h0, 32'h0, 48'h0, 8'd1, 1'b1, 12'h0, 12'hFFF}, 1'b1,
        '{STAT_FILL, 8'd0, 12'h0, 12'hFFF, 1'b0, 1'b0}},
      '{'{16'h0, 16'h0, 32'h0, 48'h0, 8'd5, 1'b0, 12'h1, 12'h1}, 1'b1,
        '{STAT_HIT, 8'd0, 12'h0, 12'hFFF, 1'b0, 1'b0}},
      '{'{16'h0, 16'hFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 8'd190, 1'b1, 12'hFFF, 12'h0},
        1'b1, '{STAT_FILL, 8'd1, 12'hFFF, 12'h0, 1'b0, 1'b0}},
      '{'{16'h0, 16'h1, 32'h1, 48'h1, 8'd191, 1'b1, 12'hABC, 12'h123}, 1'b1,
        '{STAT_BYPASS, 8'd0, 12'hABC, 12'h123, 1'b0, 1'b0}},
      '{'{16'h0, 16'h1, 32'h1, 48'h1, 8'd255, 1'b0, 12'hABC, 12'h123}, 1'b1,
        '{STAT_NONE, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0}},
      '{'{16'h0, 16'h2, 32'h2, 48'h2, 8'd10, 1'b0, 12'h5, 12'h5}, 1'b1,
        '{STAT_NONE, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0}},
      '{'{16'hFFFF, 16'h0, 32'h0, 48'h0, 8'd0, 1'b1, 12'h5, 12'h5}, 1'b1,
        '{STAT_NONE, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0}},
      '{'{16'hFFFF, 16'h0, 32'h0, 48'h0, 8'd3, 1'b1, 12'h7, 12'h8}, 1'b1,
        '{STAT_FILL, 8'd0, 12'h7, 12'h8, 1'b0, 1'b1}},
      '{'{16'h0, 16'h0, 32'h0, 48'h0, 8'd200, 1'b1, 12'h9, 12'h9}, 1'b1,
        '{STAT_BYPASS, 8'd0, 12'h9, 12'h9, 1'b0, 1'b1}},
      '{'{16'h0, 16'h5555, 32'hAAAA5555, 48'h5555AAAA5555, 8'd20, 1'b1, 12'h555, 12'hAAA},
        1'b0, '0},
      '{'{16'h0, 16'hAAAA, 32'h5555AAAA, 48'hAAAA5555AAAA, 8'd20, 1'b1, 12'hAAA, 12'h555},
        1'b0, '0}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      send_word(rows[i].r);
      if (rows[i].known && pending_lookups[$] != rows[i].exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: table %p predictor %p", i, rows[i].exp, pending_lookups[$]);
      end
    end
    // words 100 to 399: mostly fresh sequential keys, meant to fill the slots and evict
    rid = 16'h1234;
    for (int n = 0; n < N_RAND; n++) begin
      if ($urandom_range(199) == 0) rid = RID_W'($urandom());
      if (n >= 100 && n < 400) begin
        r = rand_word(rid);
        r.len = LEN_W'($urandom_range(1, 189)); r.tag = {16'hBEEF, n[31:0]};
        if ($urandom_range(3) == 0 && recent.size() > 0) begin
          r = recent[$urandom_range(recent.size() - 1)];
          r.rid = rid;
        end
      end else begin
        r = rand_word(rid);
      end
      if (n == 150) hold_rx = 1'b1;
      send_word(r);
      burst = $urandom_range(30);
      if (burst == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(40)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int hold_n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        hold_n = 2000;
        repeat (hold_n) @(negedge clk);
        hold_rx = 1'b0;
      end
      out_ready <= ($urandom_range(7) < 5) || ($urandom_range(15) == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        lookup_t e;
        e = pending_lookups.pop_front();
        if (status !== e.st || slot_index !== e.slot || out_width !== e.w ||
            out_height !== e.h || evicted !== e.ev || cleared !== e.cl) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d slot=%0d w=%0d h=%0d ev=%0b cl=%0b",
                      " got st=%0d slot=%0d w=%0d h=%0d ev=%0b cl=%0b"},
                     e.st, e.slot, e.w, e.h, e.ev, e.cl,
                     status, slot_index, out_width, out_height, evicted, cleared);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ltc_pkg.sv
rtl/ltc_ram.sv
rtl/lru_text_cache_lookup.sv
tb/sv/tb.sv
